### design/anml_pkg.sv
// Shared types, constants and the blob tile table for the autotile neighbour mask lookup.
// No dependencies; every other design file refers to this package by scoped names.
package anml_pkg;

  // Width of every tile code field on the ports.
  localparam int CodeFieldWidth = 8;
  // Default number of low code bits that take part in the comparisons.
  localparam int DefaultCodeWidth = 8;
  localparam int NumNeighbours = 8;

  // Neighbour positions, as used in inside_mask and in the blob mask.
  localparam int DirN  = 0;
  localparam int DirNe = 1;
  localparam int DirE  = 2;
  localparam int DirSe = 3;
  localparam int DirS  = 4;
  localparam int DirSw = 5;
  localparam int DirW  = 6;
  localparam int DirNw = 7;

  typedef logic [NumNeighbours-1:0] nbr_bits_t;

  typedef struct packed {
    logic [3:0] column;
    logic [1:0] turns;
  } tile_sel_t;

  // Fixed 47-entry blob table. Masks that are not listed select column 0, no rotation.
  function automatic tile_sel_t blob_lookup(input logic [7:0] mask);
    tile_sel_t sel;
    sel = '{column: 4'd0, turns: 2'd0};
    unique case (mask)
      8'd0:   sel = '{column: 4'd0,  turns: 2'd0};
      8'd1:   sel = '{column: 4'd1,  turns: 2'd0};
      8'd4:   sel = '{column: 4'd1,  turns: 2'd1};
      8'd16:  sel = '{column: 4'd1,  turns: 2'd2};
      8'd64:  sel = '{column: 4'd1,  turns: 2'd3};
      8'd5:   sel = '{column: 4'd2,  turns: 2'd0};
      8'd20:  sel = '{column: 4'd2,  turns: 2'd1};
      8'd80:  sel = '{column: 4'd2,  turns: 2'd2};
      8'd65:  sel = '{column: 4'd2,  turns: 2'd3};
      8'd7:   sel = '{column: 4'd3,  turns: 2'd0};
      8'd28:  sel = '{column: 4'd3,  turns: 2'd1};
      8'd112: sel = '{column: 4'd3,  turns: 2'd2};
      8'd193: sel = '{column: 4'd3,  turns: 2'd3};
      8'd17:  sel = '{column: 4'd4,  turns: 2'd0};
      8'd68:  sel = '{column: 4'd4,  turns: 2'd1};
      8'd21:  sel = '{column: 4'd5,  turns: 2'd0};
      8'd84:  sel = '{column: 4'd5,  turns: 2'd1};
      8'd81:  sel = '{column: 4'd5,  turns: 2'd2};
      8'd69:  sel = '{column: 4'd5,  turns: 2'd3};
      8'd23:  sel = '{column: 4'd6,  turns: 2'd0};
      8'd92:  sel = '{column: 4'd6,  turns: 2'd1};
      8'd113: sel = '{column: 4'd6,  turns: 2'd2};
      8'd197: sel = '{column: 4'd6,  turns: 2'd3};
      8'd29:  sel = '{column: 4'd7,  turns: 2'd0};
      8'd116: sel = '{column: 4'd7,  turns: 2'd1};
      8'd209: sel = '{column: 4'd7,  turns: 2'd2};
      8'd71:  sel = '{column: 4'd7,  turns: 2'd3};
      8'd31:  sel = '{column: 4'd8,  turns: 2'd0};
      8'd124: sel = '{column: 4'd8,  turns: 2'd1};
      8'd241: sel = '{column: 4'd8,  turns: 2'd2};
      8'd199: sel = '{column: 4'd8,  turns: 2'd3};
      8'd85:  sel = '{column: 4'd9,  turns: 2'd0};
      8'd87:  sel = '{column: 4'd10, turns: 2'd0};
      8'd93:  sel = '{column: 4'd10, turns: 2'd1};
      8'd117: sel = '{column: 4'd10, turns: 2'd2};
      8'd213: sel = '{column: 4'd10, turns: 2'd3};
      8'd95:  sel = '{column: 4'd11, turns: 2'd0};
      8'd125: sel = '{column: 4'd11, turns: 2'd1};
      8'd245: sel = '{column: 4'd11, turns: 2'd2};
      8'd215: sel = '{column: 4'd11, turns: 2'd3};
      8'd119: sel = '{column: 4'd12, turns: 2'd0};
      8'd221: sel = '{column: 4'd12, turns: 2'd1};
      8'd127: sel = '{column: 4'd13, turns: 2'd0};
      8'd253: sel = '{column: 4'd13, turns: 2'd1};
      8'd247: sel = '{column: 4'd13, turns: 2'd2};
      8'd223: sel = '{column: 4'd13, turns: 2'd3};
      8'd255: sel = '{column: 4'd14, turns: 2'd0};
      default: sel = '{column: 4'd0, turns: 2'd0};
    endcase
    return sel;
  endfunction

endpackage

### design/anml_neighbour_match.sv
// Decides for each of the eight neighbours whether it counts as present.
// Depends on anml_pkg for the code width and neighbour count.
module anml_neighbour_match #(
  parameter int CODE_WIDTH = anml_pkg::DefaultCodeWidth
) (
  input  logic [anml_pkg::CodeFieldWidth-1:0] center_code_i,
  input  logic                                merged_i,
  input  logic [anml_pkg::NumNeighbours-1:0]  inside_mask_i,
  input  logic [anml_pkg::CodeFieldWidth-1:0] codes_i [anml_pkg::NumNeighbours],
  output anml_pkg::nbr_bits_t                 present_o
);

  // Only the low code bits take part, and never more than the field holds.
  localparam int CmpWidth = (CODE_WIDTH < anml_pkg::CodeFieldWidth) ?
                            CODE_WIDTH : anml_pkg::CodeFieldWidth;

  logic [CmpWidth-1:0] center_cmp;

  assign center_cmp = center_code_i[CmpWidth-1:0];

  always_comb begin
    for (int k = 0; k < anml_pkg::NumNeighbours; k++) begin
      present_o[k] = !inside_mask_i[k]
                  || (codes_i[k][CmpWidth-1:0] == center_cmp)
                  || (merged_i && (codes_i[k][CmpWidth-1:0] != '0));
    end
  end

endmodule

### design/autotile_neighbour_mask_lookup.sv
// Top level of the autotile neighbour mask lookup: a three-stage pipeline.
// Depends on anml_pkg and anml_neighbour_match.
//
// Usage
// -----
// One input word describes one map cell: its tile code, the merged-style flag, the mask
// of neighbours that lie inside the map and the eight neighbour codes. For each word the
// block returns one output word holding the 8-bit blob mask and the tileset column and
// quarter-turn rotation taken from the fixed blob table.
// Both channels use valid and stall. A word is taken at a rising edge where valid is high
// and stall is low; the receiver drives stall.
// There are three register stages: stage one registers the neighbour comparisons, stage
// two builds the blob mask with its corner rule, stage three looks up the table into the
// output register. valid_o rises when an accepted word reaches the output register.
// The pipeline accepts one word a cycle while stall_o is low.
// When the receiver stalls, the output word holds; earlier stages keep filling any empty
// slot, and stall_o rises only once every stage holds a word, so nothing is lost or
// repeated. Reset clears all valid bits; no word is in flight afterwards.
module autotile_neighbour_mask_lookup #(
  parameter int CODE_WIDTH = anml_pkg::DefaultCodeWidth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       stall_o,
  input  logic [7:0] center_code_i,
  input  logic       merged_i,
  input  logic [7:0] inside_mask_i,
  input  logic [7:0] code_n_i,
  input  logic [7:0] code_ne_i,
  input  logic [7:0] code_e_i,
  input  logic [7:0] code_se_i,
  input  logic [7:0] code_s_i,
  input  logic [7:0] code_sw_i,
  input  logic [7:0] code_w_i,
  input  logic [7:0] code_nw_i,
  output logic       valid_o,
  input  logic       stall_i,
  output logic [7:0] blob_mask_o,
  output logic [3:0] tile_column_o,
  output logic [1:0] quarter_turns_o
);

  // Neighbour codes gathered in direction order.
  logic [anml_pkg::CodeFieldWidth-1:0] codes [anml_pkg::NumNeighbours];

  assign codes[anml_pkg::DirN]  = code_n_i;
  assign codes[anml_pkg::DirNe] = code_ne_i;
  assign codes[anml_pkg::DirE]  = code_e_i;
  assign codes[anml_pkg::DirSe] = code_se_i;
  assign codes[anml_pkg::DirS]  = code_s_i;
  assign codes[anml_pkg::DirSw] = code_sw_i;
  assign codes[anml_pkg::DirW]  = code_w_i;
  assign codes[anml_pkg::DirNw] = code_nw_i;

  // Stage registers with their valid bits.
  logic                v1_q, v1_d;
  logic                v2_q, v2_d;
  logic                v3_q, v3_d;
  anml_pkg::nbr_bits_t present_d, present_q;
  logic [7:0]          mask_d, mask2_q, mask3_q;
  anml_pkg::tile_sel_t sel_d, sel_q;

  // Each stage may take a new word when it is empty or its own word moves on.
  logic adv1, adv2, adv3;

  assign adv3    = !v3_q || !stall_i;
  assign adv2    = !v2_q || adv3;
  assign adv1    = !v1_q || adv2;
  assign stall_o = !adv1;

  // Stage one: neighbour presence.
  anml_neighbour_match #(
    .CODE_WIDTH(CODE_WIDTH)
  ) u_match (
    .center_code_i(center_code_i),
    .merged_i     (merged_i),
    .inside_mask_i(inside_mask_i),
    .codes_i      (codes),
    .present_o    (present_d)
  );

  // Stage two: cardinals pass straight through, a corner needs itself and both cardinals.
  always_comb begin
    mask_d    = '0;
    mask_d[0] = present_q[anml_pkg::DirN];
    mask_d[1] = present_q[anml_pkg::DirN] && present_q[anml_pkg::DirNe]
             && present_q[anml_pkg::DirE];
    mask_d[2] = present_q[anml_pkg::DirE];
    mask_d[3] = present_q[anml_pkg::DirE] && present_q[anml_pkg::DirSe]
             && present_q[anml_pkg::DirS];
    mask_d[4] = present_q[anml_pkg::DirS];
    mask_d[5] = present_q[anml_pkg::DirS] && present_q[anml_pkg::DirSw]
             && present_q[anml_pkg::DirW];
    mask_d[6] = present_q[anml_pkg::DirW];
    mask_d[7] = present_q[anml_pkg::DirW] && present_q[anml_pkg::DirNw]
             && present_q[anml_pkg::DirN];
  end

  // Stage three: table lookup.
  assign sel_d = anml_pkg::blob_lookup(mask2_q);

  always_comb begin
    v1_d = v1_q;
    v2_d = v2_q;
    v3_d = v3_q;
    if (adv1) begin
      v1_d = valid_i;
    end
    if (adv2) begin
      v2_d = v1_q;
    end
    if (adv3) begin
      v3_d = v2_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
    end
  end

  // Payload registers load only when a valid word moves into them.
  always_ff @(posedge clk_i) begin
    if (adv1 && valid_i) begin
      present_q <= present_d;
    end
    if (adv2 && v1_q) begin
      mask2_q <= mask_d;
    end
    if (adv3 && v2_q) begin
      mask3_q <= mask2_q;
      sel_q   <= sel_d;
    end
  end

  assign valid_o         = v3_q;
  assign blob_mask_o     = mask3_q;
  assign tile_column_o   = sel_q.column;
  assign quarter_turns_o = sel_q.turns;

  // A word can only reach the output from the stage before it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(valid_o) |-> $past(v2_q))
    else $error("output valid rose without a word in stage two");

  // The input is only held off while every stage is occupied.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> (v1_q && v2_q && v3_q && stall_i))
    else $error("input stalled while the pipeline had room");

  // A corner bit never appears without both adjacent cardinals.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> ((!blob_mask_o[1] || (blob_mask_o[0] && blob_mask_o[2]))
              && (!blob_mask_o[3] || (blob_mask_o[2] && blob_mask_o[4]))
              && (!blob_mask_o[5] || (blob_mask_o[4] && blob_mask_o[6]))
              && (!blob_mask_o[7] || (blob_mask_o[6] && blob_mask_o[0]))))
    else $error("corner bit set without its cardinals");

  // Every mask that obeys the corner rule is in the table, so column 0 means mask 0.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && (tile_column_o == 4'd0)) |-> (blob_mask_o == 8'd0))
    else $error("valid blob mask missed the tile table");

endmodule

### tb/sv/autotile_neighbour_mask_lookup_tb.sv
// Self-checking testbench for the autotile neighbour mask lookup.
// Depends on anml_pkg and the autotile_neighbour_mask_lookup RTL; a local scoreboard
// predicts the blob mask and tile choice for every cell word and checks each result.
module autotile_neighbour_mask_lookup_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          ClkPeriod   = 4;
  localparam int          ResetCycles = 11;
  localparam int          CodeBits    = anml_pkg::DefaultCodeWidth;
  // Pipeline depth plus some margin; used for the quiet spell after draining.
  localparam int          DrainCycles = 8;
  // Long receiver hold-off, in cycles, so that the pipeline fills and stalls its input.
  localparam int          HoldCycles  = 120;
  localparam int          HoldItems   = 40;
  localparam int          RandomItems = 800;
  // The cycle limit leaves plenty of headroom over the slowest legal run.
  localparam int unsigned CycleLimit  = 200_000;

  // One cell word as it is offered to the block.
  typedef struct packed {
    logic [7:0]          centre;
    logic                merged;
    anml_pkg::nbr_bits_t in_map;
    logic [7:0][7:0]     codes;   // indexed by the Dir* positions
  } cell_t;

  // One result word: blob mask and the tile chosen for it.
  typedef struct packed {
    logic [7:0] mask;
    logic [3:0] column;
    logic [1:0] turns;
  } tile_pick_t;

  // The 47 blob masks that have a tile of their own, with column and rotation.
  localparam tile_pick_t BlobTiles [47] = '{
    {8'd0,   4'd0,  2'd0},
    {8'd1,   4'd1,  2'd0}, {8'd4,   4'd1,  2'd1}, {8'd16,  4'd1,  2'd2}, {8'd64,  4'd1,  2'd3},
    {8'd5,   4'd2,  2'd0}, {8'd20,  4'd2,  2'd1}, {8'd80,  4'd2,  2'd2}, {8'd65,  4'd2,  2'd3},
    {8'd7,   4'd3,  2'd0}, {8'd28,  4'd3,  2'd1}, {8'd112, 4'd3,  2'd2}, {8'd193, 4'd3,  2'd3},
    {8'd17,  4'd4,  2'd0}, {8'd68,  4'd4,  2'd1},
    {8'd21,  4'd5,  2'd0}, {8'd84,  4'd5,  2'd1}, {8'd81,  4'd5,  2'd2}, {8'd69,  4'd5,  2'd3},
    {8'd23,  4'd6,  2'd0}, {8'd92,  4'd6,  2'd1}, {8'd113, 4'd6,  2'd2}, {8'd197, 4'd6,  2'd3},
    {8'd29,  4'd7,  2'd0}, {8'd116, 4'd7,  2'd1}, {8'd209, 4'd7,  2'd2}, {8'd71,  4'd7,  2'd3},
    {8'd31,  4'd8,  2'd0}, {8'd124, 4'd8,  2'd1}, {8'd241, 4'd8,  2'd2}, {8'd199, 4'd8,  2'd3},
    {8'd85,  4'd9,  2'd0},
    {8'd87,  4'd10, 2'd0}, {8'd93,  4'd10, 2'd1}, {8'd117, 4'd10, 2'd2}, {8'd213, 4'd10, 2'd3},
    {8'd95,  4'd11, 2'd0}, {8'd125, 4'd11, 2'd1}, {8'd245, 4'd11, 2'd2}, {8'd215, 4'd11, 2'd3},
    {8'd119, 4'd12, 2'd0}, {8'd221, 4'd12, 2'd1},
    {8'd127, 4'd13, 2'd0}, {8'd253, 4'd13, 2'd1}, {8'd247, 4'd13, 2'd2}, {8'd223, 4'd13, 2'd3},
    {8'd255, 4'd14, 2'd0}
  };

  // Scoreboard: works out the tile pick for each accepted cell word and holds the picks
  // in order until the matching result word comes out of the block.
  class tile_choice_tracker;
    tile_pick_t  awaited_tiles[$];
    int unsigned mismatches;
    int unsigned tiles_checked;

    function tile_pick_t classify_cell(cell_t site);
      anml_pkg::nbr_bits_t present;
      logic [7:0]          mask;
      logic [CodeBits-1:0] ctr;
      logic [CodeBits-1:0] nb;
      tile_pick_t          pick;
      ctr = site.centre[CodeBits-1:0];
      // A neighbour outside the map always counts; inside it must match the centre,
      // or be any nonzero code when the cell's style merges.
      for (int k = 0; k < anml_pkg::NumNeighbours; k++) begin
        nb = site.codes[k][CodeBits-1:0];
        present[k] = !site.in_map[k] || (nb == ctr) || (site.merged && nb != '0);
      end
      // Cardinals stand alone; a corner needs itself and both cardinals beside it.
      mask                  = '0;
      mask[anml_pkg::DirN]  = present[anml_pkg::DirN];
      mask[anml_pkg::DirE]  = present[anml_pkg::DirE];
      mask[anml_pkg::DirS]  = present[anml_pkg::DirS];
      mask[anml_pkg::DirW]  = present[anml_pkg::DirW];
      mask[anml_pkg::DirNe] = present[anml_pkg::DirN] && present[anml_pkg::DirNe]
                           && present[anml_pkg::DirE];
      mask[anml_pkg::DirSe] = present[anml_pkg::DirE] && present[anml_pkg::DirSe]
                           && present[anml_pkg::DirS];
      mask[anml_pkg::DirSw] = present[anml_pkg::DirS] && present[anml_pkg::DirSw]
                           && present[anml_pkg::DirW];
      mask[anml_pkg::DirNw] = present[anml_pkg::DirW] && present[anml_pkg::DirNw]
                           && present[anml_pkg::DirN];
      // Masks missing from the table fall back to column 0 with no rotation.
      pick = {mask, 4'd0, 2'd0};
      foreach (BlobTiles[k]) begin
        if (BlobTiles[k].mask == mask) begin
          pick = BlobTiles[k];
          break;
        end
      end
      return pick;
    endfunction

    function void note_cell(cell_t site);
      awaited_tiles = {awaited_tiles, classify_cell(site)};
    endfunction

    function int unsigned pending();
      return awaited_tiles.size();
    endfunction

    task flag_mismatch(string what);
      mismatches++;
      $display("MISMATCH at %0t ns: %s", $time, what);
    endtask

    task check_tile(logic [7:0] mask, logic [3:0] column, logic [1:0] turns);
      tile_pick_t want;
      if (awaited_tiles.size() == 0) begin
        flag_mismatch($sformatf("unexpected result word mask=%0d column=%0d turns=%0d",
                                mask, column, turns));
        return;
      end
      want = awaited_tiles.pop_front();
      tiles_checked++;
      if (mask !== want.mask)
        flag_mismatch($sformatf("blob_mask %0d, expected %0d", mask, want.mask));
      if (column !== want.column)
        flag_mismatch($sformatf("tile_column %0d, expected %0d (mask %0d)",
                                column, want.column, want.mask));
      if (turns !== want.turns)
        flag_mismatch($sformatf("quarter_turns %0d, expected %0d (mask %0d)",
                                turns, want.turns, want.mask));
    endtask
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       valid_i;
  logic       stall_o;
  logic [7:0] center_code_i;
  logic       merged_i;
  logic [7:0] inside_mask_i;
  logic [7:0] code_n_i;
  logic [7:0] code_ne_i;
  logic [7:0] code_e_i;
  logic [7:0] code_se_i;
  logic [7:0] code_s_i;
  logic [7:0] code_sw_i;
  logic [7:0] code_w_i;
  logic [7:0] code_nw_i;
  logic       valid_o;
  logic       stall_i;
  logic [7:0] blob_mask_o;
  logic [3:0] tile_column_o;
  logic [1:0] quarter_turns_o;

  tile_choice_tracker tracker = new();

  // Set by the stimulus to make the receiver hold off for a long stretch.
  logic        rx_hold = 1'b0;
  // While set, the sender offers back-to-back words with no idle cycles.
  bit          tx_steady = 1'b0;
  int unsigned cells_sent = 0;
  int unsigned cycle_count = 0;
  bit          masks_seen [256];
  bit          columns_seen [16];

  autotile_neighbour_mask_lookup #(
    .CODE_WIDTH(CodeBits)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (valid_i),
    .stall_o        (stall_o),
    .center_code_i  (center_code_i),
    .merged_i       (merged_i),
    .inside_mask_i  (inside_mask_i),
    .code_n_i       (code_n_i),
    .code_ne_i      (code_ne_i),
    .code_e_i       (code_e_i),
    .code_se_i      (code_se_i),
    .code_s_i       (code_s_i),
    .code_sw_i      (code_sw_i),
    .code_w_i       (code_w_i),
    .code_nw_i      (code_nw_i),
    .valid_o        (valid_o),
    .stall_i        (stall_i),
    .blob_mask_o    (blob_mask_o),
    .tile_column_o  (tile_column_o),
    .quarter_turns_o(quarter_turns_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Builds a cell in which the neighbours flagged in same carry the centre code and
  // the others carry the code given as other.
  function automatic cell_t pattern_cell(logic [7:0] centre, logic merged,
                                         anml_pkg::nbr_bits_t in_map,
                                         anml_pkg::nbr_bits_t same, logic [7:0] other);
    cell_t site;
    site.centre = centre;
    site.merged = merged;
    site.in_map = in_map;
    for (int k = 0; k < anml_pkg::NumNeighbours; k++) site.codes[k] = same[k] ? centre : other;
    return site;
  endfunction

  // Random cell biased so that neighbours often match the centre or are empty, which
  // spreads the blob masks over the whole table rather than piling up on the full mask.
  function automatic cell_t random_cell();
    cell_t       site;
    int unsigned pick;
    site.centre = ($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom);
    site.merged = 1'($urandom);
    site.in_map = $urandom_range(0, 1) ? anml_pkg::nbr_bits_t'($urandom | $urandom)
                                       : anml_pkg::nbr_bits_t'($urandom);
    for (int k = 0; k < anml_pkg::NumNeighbours; k++) begin
      pick = $urandom_range(0, 3);
      case (pick)
        0:       site.codes[k] = site.centre;
        1:       site.codes[k] = 8'h00;
        default: site.codes[k] = 8'($urandom);
      endcase
    end
    return site;
  endfunction

  // Idle cycles before the next word; now and then the sender switches between a
  // gappy mode and a back-to-back mode.
  function automatic int unsigned next_gap();
    if ($urandom_range(0, 49) == 0) tx_steady = !tx_steady;
    return tx_steady ? 0 : $urandom_range(0, 15);
  endfunction

  // Offers one cell word after the given idle gap and returns at the edge where the
  // block takes it. The payload is held steady for as long as the block stalls.
  task automatic offer_cell(input cell_t site, input int unsigned gap);
    if (gap > 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    valid_i       <= 1'b1;
    center_code_i <= site.centre;
    merged_i      <= site.merged;
    inside_mask_i <= site.in_map;
    code_n_i      <= site.codes[anml_pkg::DirN];
    code_ne_i     <= site.codes[anml_pkg::DirNe];
    code_e_i      <= site.codes[anml_pkg::DirE];
    code_se_i     <= site.codes[anml_pkg::DirSe];
    code_s_i      <= site.codes[anml_pkg::DirS];
    code_sw_i     <= site.codes[anml_pkg::DirSw];
    code_w_i      <= site.codes[anml_pkg::DirW];
    code_nw_i     <= site.codes[anml_pkg::DirNw];
    do @(posedge clk_i); while (stall_o);
    tracker.note_cell(site);
    cells_sent++;
  endtask

  task automatic wait_drained();
    while (tracker.pending() != 0) @(posedge clk_i);
  endtask

  // Result side. Outputs are sampled at the rising edge, before the block's registers
  // move, and stall_i is updated with a single nonblocking assignment per edge. After
  // each word taken the receiver draws how long to stall before the next one.
  initial begin : result_sink
    int unsigned rx_wait;
    bit          rx_steady;
    rx_wait   = 0;
    rx_steady = 1'b0;
    stall_i   = 1'b0;
    forever begin
      @(posedge clk_i);
      if (valid_o && !stall_i) begin
        tracker.check_tile(blob_mask_o, tile_column_o, quarter_turns_o);
        masks_seen[blob_mask_o]     = 1'b1;
        columns_seen[tile_column_o] = 1'b1;
        if ($urandom_range(0, 39) == 0) rx_steady = !rx_steady;
        rx_wait = rx_steady ? 0 : $urandom_range(0, 15);
      end
      if (rx_hold) begin
        stall_i <= 1'b1;
      end else if (rx_wait > 0) begin
        stall_i <= 1'b1;
        rx_wait--;
      end else begin
        stall_i <= 1'b0;
      end
    end
  end

  // Watchdog: ends the run if it has not finished within the cycle limit.
  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
             tracker.pending());
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    cell_t       directed[$];
    cell_t       odd_cell;
    int unsigned n_masks;
    int unsigned n_columns;

    rst_ni        = 1'b0;
    valid_i       = 1'b0;
    center_code_i = '0;
    merged_i      = 1'b0;
    inside_mask_i = '0;
    code_n_i      = '0;
    code_ne_i     = '0;
    code_e_i      = '0;
    code_se_i     = '0;
    code_s_i      = '0;
    code_sw_i     = '0;
    code_w_i      = '0;
    code_nw_i     = '0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed cells. Every neighbour outside the map: all present whatever the codes.
    directed = {directed, pattern_cell(8'h00, 1'b0, 8'h00, 8'h00, 8'h00)};
    directed = {directed, pattern_cell(8'hFF, 1'b0, 8'h00, 8'h00, 8'h00)};
    // All inside, none matching: the empty mask.
    directed = {directed, pattern_cell(8'h05, 1'b0, 8'hFF, 8'h00, 8'h06)};
    // All inside and all equal to the centre at the top of the code range.
    directed = {directed, pattern_cell(8'hFF, 1'b0, 8'hFF, 8'hFF, 8'h00)};
    // Merged style: zero codes never count, nonzero ones always do.
    directed = {directed, pattern_cell(8'h09, 1'b1, 8'hFF, 8'h00, 8'h00)};
    directed = {directed, pattern_cell(8'h09, 1'b1, 8'hFF, 8'h00, 8'hF0)};
    directed = {directed, pattern_cell(8'hFF, 1'b1, 8'hFF, 8'h00, 8'hFE)};
    // A zero centre matches zero neighbours even with merging on.
    directed = {directed, pattern_cell(8'h00, 1'b1, 8'hFF, 8'h00, 8'h00)};
    // Each cardinal on its own.
    directed = {directed, pattern_cell(8'h02, 1'b0, 8'hFF,
                anml_pkg::nbr_bits_t'(1) << anml_pkg::DirN, 8'h01)};
    directed = {directed, pattern_cell(8'h02, 1'b0, 8'hFF,
                anml_pkg::nbr_bits_t'(1) << anml_pkg::DirE, 8'h01)};
    directed = {directed, pattern_cell(8'h02, 1'b0, 8'hFF,
                anml_pkg::nbr_bits_t'(1) << anml_pkg::DirS, 8'h01)};
    directed = {directed, pattern_cell(8'h02, 1'b0, 8'hFF,
                anml_pkg::nbr_bits_t'(1) << anml_pkg::DirW, 8'h01)};
    // Corners alone do not count without their cardinals.
    directed = {directed, pattern_cell(8'h33, 1'b0, 8'hFF, 8'hAA, 8'hCC)};
    // Two cardinals with the corner between them missing, then present.
    directed = {directed, pattern_cell(8'h40, 1'b0, 8'hFF,
                (anml_pkg::nbr_bits_t'(1) << anml_pkg::DirN) |
                (anml_pkg::nbr_bits_t'(1) << anml_pkg::DirE), 8'h41)};
    directed = {directed, pattern_cell(8'h40, 1'b0, 8'hFF,
                (anml_pkg::nbr_bits_t'(1) << anml_pkg::DirN) |
                (anml_pkg::nbr_bits_t'(1) << anml_pkg::DirNe) |
                (anml_pkg::nbr_bits_t'(1) << anml_pkg::DirE), 8'h41)};
    // Everything but one corner.
    directed = {directed, pattern_cell(8'h7E, 1'b0, 8'hFF,
                ~(anml_pkg::nbr_bits_t'(1) << anml_pkg::DirSe), 8'h81)};
    // Only the south neighbour lies outside the map.
    directed = {directed, pattern_cell(8'h22, 1'b0,
                ~(anml_pkg::nbr_bits_t'(1) << anml_pkg::DirS), 8'h00, 8'h11)};
    // Corners outside, cardinals inside and different: still the empty mask.
    directed = {directed, pattern_cell(8'h5A, 1'b0, 8'h55, 8'h00, 8'hA5)};
    // Cardinals outside, corners inside and different: only the cardinal bits.
    directed = {directed, pattern_cell(8'hA5, 1'b0, 8'hAA, 8'h00, 8'h5A)};
    // The N to Se neighbours match the centre; the others differ from it in every bit.
    directed = {directed, pattern_cell(8'h80, 1'b0, 8'hFF, 8'h0F, 8'h7F)};
    // Merged style with a mix of empty and full neighbours.
    odd_cell = pattern_cell(8'h10, 1'b1, 8'hFF, 8'h00, 8'h00);
    odd_cell.codes[anml_pkg::DirN]  = 8'hFF;
    odd_cell.codes[anml_pkg::DirNe] = 8'h80;
    odd_cell.codes[anml_pkg::DirE]  = 8'h01;
    directed = {directed, odd_cell};
    foreach (directed[i]) offer_cell(directed[i], next_gap());
    valid_i <= 1'b0;

    // Let everything drain before the back-pressure test.
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);

    // The receiver holds off for a long stretch while the sender keeps offering words
    // back to back, so the pipeline fills and stall_o rises and later releases.
    fork
      begin
        rx_hold <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        rx_hold <= 1'b0;
      end
      begin
        repeat (HoldItems) offer_cell(random_cell(), 0);
      end
    join

    // Random traffic, with one pause in the middle until every result has come back.
    for (int i = 0; i < RandomItems; i++) begin
      offer_cell(random_cell(), next_gap());
      if (i == RandomItems / 2) begin
        valid_i <= 1'b0;
        wait_drained();
        repeat (DrainCycles) @(posedge clk_i);
      end
    end
    valid_i <= 1'b0;

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);

    n_masks   = 0;
    n_columns = 0;
    foreach (masks_seen[m]) n_masks += masks_seen[m];
    foreach (columns_seen[c]) n_columns += columns_seen[c];
    $display("Classified %0d cells and checked %0d result words, %0d field mismatches.",
             cells_sent, tracker.tiles_checked, tracker.mismatches);
    $display("Saw %0d distinct blob masks and %0d of 15 tile columns, with output hold-off.",
             n_masks, n_columns);
    if (tracker.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
